// ===== rtl/core/lz10_pkg.sv =====
`timescale 1ns / 1ps

package lz10_pkg;

    localparam logic [7:0] METHOD_ID = 8'h10;
    localparam logic [4:0] LEN_BIAS  = 5'd3;

    localparam logic [2:0] ST_DATA       = 3'd0;
    localparam logic [2:0] ST_BAD_METHOD = 3'd1;
    localparam logic [2:0] ST_ZERO_SIZE  = 3'd2;
    localparam logic [2:0] ST_TRUNC      = 3'd3;
    localparam logic [2:0] ST_BAD_REF    = 3'd4;

    typedef enum logic [2:0] {
        S_HEADER,
        S_FLAG,
        S_ITEM,
        S_REF2,
        S_READ,
        S_COPY,
        S_DRAIN
    } t_state;

    typedef struct packed {
        logic       hdr_step;
        logic       flag_load;
        logic       flag_next;
        logic       ref1_load;
        logic       ref_setup;
        logic       rd_first;
        logic       rd_next;
        logic       put_lit;
        logic       put_copy;
        logic       emit_err;
        logic [2:0] err_code;
        logic       rearm;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic hdr_first;
        logic hdr_last;
        logic method_ok;
        logic size_zero;
        logic flag_is_ref;
        logic flag_last;
        logic rem_one;
        logic rem_gt1;
        logic rem_gt_len;
        logic bad_ref;
        logic cnt_last;
        logic ref_eos;
    } t_sts;

endpackage

// ===== rtl/core/lz10_ram.sv =====
`timescale 1ns / 1ps

module lz10_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/lz10_ctrl.sv =====
`timescale 1ns / 1ps

module lz10_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_end_of_source,
    input  lz10_pkg::t_sts i_sts,
    output lz10_pkg::t_cmd o_cmd,
    output logic           o_stall
);

    import lz10_pkg::*;

    t_state     r_state;
    t_state     n_state;
    logic       take;
    logic       err;
    logic [2:0] code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HEADER;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        err     = 1'b0;
        code    = ST_DATA;
        take    = i_valid && i_sts.out_free;
        case (r_state)
            S_HEADER: begin
                o_stall = !i_sts.out_free;
                if (take) begin
                    if (i_sts.hdr_first && !i_sts.method_ok) begin
                        err  = 1'b1;
                        code = ST_BAD_METHOD;
                    end else if (i_sts.hdr_last && i_sts.size_zero) begin
                        err  = 1'b1;
                        code = ST_ZERO_SIZE;
                    end else if (i_end_of_source) begin
                        err  = 1'b1;
                        code = ST_TRUNC;
                    end else begin
                        o_cmd.hdr_step = 1'b1;
                        if (i_sts.hdr_last) begin
                            n_state = S_FLAG;
                        end
                    end
                end
            end
            S_FLAG: begin
                o_stall = !i_sts.out_free;
                if (take) begin
                    if (i_end_of_source) begin
                        err  = 1'b1;
                        code = ST_TRUNC;
                    end else begin
                        o_cmd.flag_load = 1'b1;
                        n_state         = S_ITEM;
                    end
                end
            end
            S_ITEM: begin
                o_stall = !i_sts.out_free;
                if (take) begin
                    if (i_sts.flag_is_ref) begin
                        if (i_end_of_source) begin
                            err  = 1'b1;
                            code = ST_TRUNC;
                        end else begin
                            o_cmd.ref1_load = 1'b1;
                            n_state         = S_REF2;
                        end
                    end else if (i_end_of_source && i_sts.rem_gt1) begin
                        err  = 1'b1;
                        code = ST_TRUNC;
                    end else begin
                        o_cmd.put_lit = 1'b1;
                        if (i_sts.rem_one) begin
                            o_cmd.rearm = 1'b1;
                            n_state     = i_end_of_source ? S_HEADER : S_DRAIN;
                        end else begin
                            o_cmd.flag_next = 1'b1;
                            n_state         = i_sts.flag_last ? S_FLAG : S_ITEM;
                        end
                    end
                end
            end
            S_REF2: begin
                o_stall = !i_sts.out_free;
                if (take) begin
                    if (i_sts.bad_ref) begin
                        err  = 1'b1;
                        code = ST_BAD_REF;
                    end else if (i_end_of_source && i_sts.rem_gt_len) begin
                        err  = 1'b1;
                        code = ST_TRUNC;
                    end else begin
                        o_cmd.ref_setup = 1'b1;
                        n_state         = S_READ;
                    end
                end
            end
            S_READ: begin
                o_cmd.rd_first = 1'b1;
                n_state        = S_COPY;
            end
            S_COPY: begin
                if (i_sts.out_free) begin
                    o_cmd.put_copy = 1'b1;
                    if (i_sts.cnt_last) begin
                        if (i_sts.rem_one) begin
                            o_cmd.rearm = 1'b1;
                            n_state     = i_sts.ref_eos ? S_HEADER : S_DRAIN;
                        end else begin
                            o_cmd.flag_next = 1'b1;
                            n_state         = i_sts.flag_last ? S_FLAG : S_ITEM;
                        end
                    end else begin
                        o_cmd.rd_next = 1'b1;
                    end
                end
            end
            S_DRAIN: begin
                o_stall = 1'b0;
                if (i_valid && i_end_of_source) begin
                    o_cmd.rearm = 1'b1;
                    n_state     = S_HEADER;
                end
            end
            default: begin
                n_state = S_HEADER;
            end
        endcase
        if (err) begin
            o_cmd.emit_err = 1'b1;
            o_cmd.err_code = code;
            o_cmd.rearm    = 1'b1;
            n_state        = i_end_of_source ? S_HEADER : S_DRAIN;
        end
    end

endmodule

// ===== rtl/core/lz10_dp.sv =====
`timescale 1ns / 1ps

module lz10_dp #(
    parameter int HISTORY_DEPTH = 4096
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [7:0]     i_in_byte,
    input  logic           i_end_of_source,
    input  logic           i_stall,
    input  lz10_pkg::t_cmd i_cmd,
    output lz10_pkg::t_sts o_sts,
    output logic           o_valid,
    output logic [7:0]     o_out_byte,
    output logic [2:0]     o_status,
    output logic           o_run_end,
    output logic           o_stream_end
);

    import lz10_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam int SW = AW + 1;
    localparam logic [AW-1:0] PTR_LAST = AW'(HISTORY_DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(HISTORY_DEPTH);
    localparam logic [SW-1:0] DEPTH_S  = SW'(HISTORY_DEPTH);

    logic [1:0]    r_hdr_idx, n_hdr_idx;
    logic [23:0]   r_rem, n_rem;
    logic [7:0]    r_flags, n_flags;
    logic [2:0]    r_fidx, n_fidx;
    logic [7:0]    r_ref1, n_ref1;
    logic [AW-1:0] r_wp, n_wp;
    logic [CW-1:0] r_wcnt, n_wcnt;
    logic [AW-1:0] r_src, n_src;
    logic [4:0]    r_cnt, n_cnt;
    logic          r_eos, n_eos;
    logic          r_valid, n_valid;
    logic [7:0]    r_obyte;
    logic [2:0]    r_ostatus;
    logic          r_orun, r_ostream;
    logic          r_byp_hit;
    logic [7:0]    r_byp_data;

    logic [4:0]    len;
    logic [12:0]   ref_dist;
    logic          rem_lt_len;
    logic [4:0]    len_eff;
    logic [SW-1:0] src_diff;
    logic [AW-1:0] src_start;
    logic [AW-1:0] src_inc;
    logic [AW-1:0] wp_inc;
    logic [AW-1:0] rd_addr;
    logic          rd_en;
    logic          we;
    logic [7:0]    wdata;
    logic [7:0]    ram_q;
    logic [7:0]    copy_byte;
    logic          emit;
    logic          out_free;

    assign out_free   = !r_valid || !i_stall;
    assign len        = {1'b0, r_ref1[7:4]} + LEN_BIAS;
    assign ref_dist   = {1'b0, r_ref1[3:0], i_in_byte} + 13'd1;
    assign rem_lt_len = r_rem < 24'(len);
    assign len_eff    = rem_lt_len ? r_rem[4:0] : len;
    assign src_diff   = {1'b0, r_wp} - SW'(ref_dist);
    assign src_start  = src_diff[SW-1] ? AW'(src_diff + DEPTH_S) : src_diff[AW-1:0];
    assign src_inc    = (r_src == PTR_LAST) ? '0 : r_src + 1'b1;
    assign wp_inc     = (r_wp == PTR_LAST) ? '0 : r_wp + 1'b1;
    assign rd_en      = i_cmd.rd_first || i_cmd.rd_next;
    assign rd_addr    = i_cmd.rd_next ? src_inc : r_src;
    assign copy_byte  = r_byp_hit ? r_byp_data : ram_q;
    assign we         = i_cmd.put_lit || i_cmd.put_copy;
    assign wdata      = i_cmd.put_lit ? i_in_byte : copy_byte;
    assign emit       = we || i_cmd.emit_err;

    lz10_ram #(
        .WIDTH(8),
        .DEPTH(HISTORY_DEPTH)
    ) u_hist (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(r_wp),
        .i_wdata(wdata),
        .i_re   (rd_en),
        .i_raddr(rd_addr),
        .o_rdata(ram_q)
    );

    always_comb begin
        o_sts.out_free    = out_free;
        o_sts.hdr_first   = (r_hdr_idx == 2'd0);
        o_sts.hdr_last    = (r_hdr_idx == 2'd3);
        o_sts.method_ok   = (i_in_byte == METHOD_ID);
        o_sts.size_zero   = (r_rem[15:0] == 16'd0) && (i_in_byte == 8'd0);
        o_sts.flag_is_ref = r_flags[3'd7 - r_fidx];
        o_sts.flag_last   = (r_fidx == 3'd7);
        o_sts.rem_one     = (r_rem == 24'd1);
        o_sts.rem_gt1     = (r_rem > 24'd1);
        o_sts.rem_gt_len  = (r_rem > 24'(len));
        o_sts.bad_ref     = (r_wcnt < CW'(ref_dist));
        o_sts.cnt_last    = (r_cnt == 5'd1);
        o_sts.ref_eos     = r_eos;
    end

    always_comb begin
        n_hdr_idx = r_hdr_idx;
        n_rem     = r_rem;
        n_flags   = r_flags;
        n_fidx    = r_fidx;
        n_ref1    = r_ref1;
        n_wp      = r_wp;
        n_wcnt    = r_wcnt;
        n_src     = r_src;
        n_cnt     = r_cnt;
        n_eos     = r_eos;
        if (i_cmd.hdr_step) begin
            n_hdr_idx = r_hdr_idx + 2'd1;
            case (r_hdr_idx)
                2'd0:    n_rem = '0;
                2'd1:    n_rem[7:0] = i_in_byte;
                2'd2:    n_rem[15:8] = i_in_byte;
                2'd3:    n_rem[23:16] = i_in_byte;
                default: n_rem = r_rem;
            endcase
        end
        if (i_cmd.flag_load) begin
            n_flags = i_in_byte;
            n_fidx  = '0;
        end
        if (i_cmd.flag_next) begin
            n_fidx = r_fidx + 3'd1;
        end
        if (i_cmd.ref1_load) begin
            n_ref1 = i_in_byte;
        end
        if (i_cmd.ref_setup) begin
            n_src = src_start;
            n_cnt = len_eff;
            n_eos = i_end_of_source;
        end
        if (i_cmd.rd_next) begin
            n_src = src_inc;
        end
        if (we) begin
            n_wp  = wp_inc;
            n_rem = r_rem - 24'd1;
            if (r_wcnt != CNT_FULL) begin
                n_wcnt = r_wcnt + 1'b1;
            end
        end
        if (i_cmd.put_copy) begin
            n_cnt = r_cnt - 5'd1;
        end
        if (i_cmd.rearm) begin
            n_hdr_idx = '0;
            n_rem     = '0;
            n_flags   = '0;
            n_fidx    = '0;
            n_ref1    = '0;
            n_wp      = '0;
            n_wcnt    = '0;
        end
        if (emit) begin
            n_valid = 1'b1;
        end else begin
            n_valid = r_valid && i_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_idx <= '0;
            r_rem     <= '0;
            r_flags   <= '0;
            r_fidx    <= '0;
            r_ref1    <= '0;
            r_wp      <= '0;
            r_wcnt    <= '0;
            r_src     <= '0;
            r_cnt     <= '0;
            r_eos     <= 1'b0;
            r_valid   <= 1'b0;
            r_byp_hit <= 1'b0;
        end else begin
            r_hdr_idx <= n_hdr_idx;
            r_rem     <= n_rem;
            r_flags   <= n_flags;
            r_fidx    <= n_fidx;
            r_ref1    <= n_ref1;
            r_wp      <= n_wp;
            r_wcnt    <= n_wcnt;
            r_src     <= n_src;
            r_cnt     <= n_cnt;
            r_eos     <= n_eos;
            r_valid   <= n_valid;
            if (rd_en) begin
                r_byp_hit <= we && (rd_addr == r_wp);
            end
        end
    end

    // read-during-write forwarding for distance one
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_byp_data <= wdata;
        end
        if (emit) begin
            r_obyte   <= i_cmd.emit_err ? 8'd0 : wdata;
            r_ostatus <= i_cmd.emit_err ? i_cmd.err_code : ST_DATA;
            r_orun    <= i_cmd.emit_err || i_cmd.put_lit || o_sts.cnt_last;
            r_ostream <= i_cmd.emit_err || o_sts.rem_one;
        end
    end

    assign o_valid      = r_valid;
    assign o_out_byte   = r_obyte;
    assign o_status     = r_ostatus;
    assign o_run_end    = r_orun;
    assign o_stream_end = r_ostream;

endmodule

// ===== rtl/core/lz10_decompressor.sv =====
`timescale 1ns / 1ps

// LZ10 stream decompressor.
// Input channel: one compressed source byte per request (i_in_byte), with
// i_end_of_source marking the last byte; taken when i_valid is high and
// o_stall is low. Output channel: one result per request (o_out_byte,
// o_status, o_run_end, o_stream_end) when o_valid is high and i_stall low.
// Header, flag and first reference bytes give no result; a literal's byte
// is presented the next cycle.
// A back-reference of length L (cut to the bytes left) runs from its second
// byte: the cycle that takes it sets up the copy, a read of history follows,
// then one byte per cycle while the receiver does not stall, paced by the one
// read port and one write port of the history RAM. Input is stalled while a
// copy runs. Errors give one result with a nonzero status.
// The registered output lets a new request in as the waiting result is taken;
// while the receiver stalls, the copy and the input pause and nothing is lost.
// Reset (synchronous, active low) arms the block for a new stream header;
// history contents are not cleared and are never read before being written.

module lz10_decompressor #(
    parameter int HISTORY_DEPTH = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_source,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic [2:0] o_status,
    output logic       o_run_end,
    output logic       o_stream_end
);

    import lz10_pkg::*;

    t_cmd cmd;
    t_sts sts;

    lz10_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_end_of_source(i_end_of_source),
        .i_sts          (sts),
        .o_cmd          (cmd),
        .o_stall        (o_stall)
    );

    lz10_dp #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_byte      (i_in_byte),
        .i_end_of_source(i_end_of_source),
        .i_stall        (i_stall),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_valid        (o_valid),
        .o_out_byte     (o_out_byte),
        .o_status       (o_status),
        .o_run_end      (o_run_end),
        .o_stream_end   (o_stream_end)
    );

    a_copy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.put_copy |-> o_stall)
        else $error("input taken during copy");

    a_one_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.put_lit, cmd.put_copy, cmd.emit_err}))
        else $error("conflicting result sources");

    a_err_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_DATA)) |-> (o_stream_end && o_run_end))
        else $error("error result without end marks");

endmodule
